FILE: hdl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types and constants of the affine bounding-box transform.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int SLOT_W    = 32;   // one coordinate or matrix entry slot
    localparam int REG_W     = 64;   // one configuration register
    localparam int REG_IDX_W = 3;
    localparam int AXES      = 3;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW0_C01 = 3'd0,
        REG_ROW0_C23 = 3'd1,
        REG_ROW1_C01 = 3'd2,
        REG_ROW1_C23 = 3'd3,
        REG_ROW2_C01 = 3'd4,
        REG_ROW2_C23 = 3'd5
    } t_reg_idx;

    // Identity transform after reset
    localparam logic [REG_W-1:0] RST_ROW0_C01 = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] RST_ROW0_C23 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW1_C01 = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW1_C23 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_C01 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_C23 = 64'h0000_0000_0001_0000;

    // Box corners; mn[0] (min x) sits in the lowest bits
    typedef struct packed {
        logic [AXES-1:0][SLOT_W-1:0] mx;
        logic [AXES-1:0][SLOT_W-1:0] mn;
    } t_box;

    // Matrix m[row][col] and translation t[row], raw slots
    typedef struct packed {
        logic [AXES-1:0][AXES-1:0][SLOT_W-1:0] m;
        logic [AXES-1:0][SLOT_W-1:0]           t;
    } t_matrix;

endpackage

FILE: hdl/aat_cfg.sv
// ----------------------------------------------------------------------------
// aat_cfg
// Configuration register file holding the 3x4 affine matrix.
// ----------------------------------------------------------------------------
module aat_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aat_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aat_pkg::REG_W-1:0]      i_cfg_wdata,
    output aat_pkg::t_matrix               o_mat
);

    logic [aat_pkg::REG_W-1:0] r_row0_c01, r_row0_c23;
    logic [aat_pkg::REG_W-1:0] r_row1_c01, r_row1_c23;
    logic [aat_pkg::REG_W-1:0] r_row2_c01, r_row2_c23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_c01 <= aat_pkg::RST_ROW0_C01;
            r_row0_c23 <= aat_pkg::RST_ROW0_C23;
            r_row1_c01 <= aat_pkg::RST_ROW1_C01;
            r_row1_c23 <= aat_pkg::RST_ROW1_C23;
            r_row2_c01 <= aat_pkg::RST_ROW2_C01;
            r_row2_c23 <= aat_pkg::RST_ROW2_C23;
        end else if (i_cfg_we) begin
            case (aat_pkg::t_reg_idx'(i_cfg_idx))
                aat_pkg::REG_ROW0_C01: r_row0_c01 <= i_cfg_wdata;
                aat_pkg::REG_ROW0_C23: r_row0_c23 <= i_cfg_wdata;
                aat_pkg::REG_ROW1_C01: r_row1_c01 <= i_cfg_wdata;
                aat_pkg::REG_ROW1_C23: r_row1_c23 <= i_cfg_wdata;
                aat_pkg::REG_ROW2_C01: r_row2_c01 <= i_cfg_wdata;
                aat_pkg::REG_ROW2_C23: r_row2_c23 <= i_cfg_wdata;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_comb begin
        o_mat.m[0][0] = r_row0_c01[31:0];
        o_mat.m[0][1] = r_row0_c01[63:32];
        o_mat.m[0][2] = r_row0_c23[31:0];
        o_mat.t[0]    = r_row0_c23[63:32];
        o_mat.m[1][0] = r_row1_c01[31:0];
        o_mat.m[1][1] = r_row1_c01[63:32];
        o_mat.m[1][2] = r_row1_c23[31:0];
        o_mat.t[1]    = r_row1_c23[63:32];
        o_mat.m[2][0] = r_row2_c01[31:0];
        o_mat.m[2][1] = r_row2_c01[63:32];
        o_mat.m[2][2] = r_row2_c23[31:0];
        o_mat.t[2]    = r_row2_c23[63:32];
    end

endmodule

FILE: hdl/aat_prod.sv
// ----------------------------------------------------------------------------
// aat_prod
// Product stage: corner-by-entry products, floor shift, min/max ordering.
// ----------------------------------------------------------------------------
module aat_prod #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int TERM_W     = 2*COORD_BITS - FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  aat_pkg::t_box            i_box,
    input  aat_pkg::t_matrix         i_mat,
    output logic signed [TERM_W-1:0] o_lo_term [aat_pkg::AXES][aat_pkg::AXES],
    output logic signed [TERM_W-1:0] o_hi_term [aat_pkg::AXES][aat_pkg::AXES],
    output logic                     o_box_ok
);

    localparam int PROD_W = 2*COORD_BITS;

    logic signed [COORD_BITS-1:0] lo_c [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] hi_c [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] m_c  [aat_pkg::AXES][aat_pkg::AXES];
    logic signed [PROD_W-1:0]     pa   [aat_pkg::AXES][aat_pkg::AXES];
    logic signed [PROD_W-1:0]     pb   [aat_pkg::AXES][aat_pkg::AXES];
    logic signed [TERM_W-1:0]     sa   [aat_pkg::AXES][aat_pkg::AXES];
    logic signed [TERM_W-1:0]     sb   [aat_pkg::AXES][aat_pkg::AXES];
    logic signed [TERM_W-1:0]     n_lo [aat_pkg::AXES][aat_pkg::AXES];
    logic signed [TERM_W-1:0]     n_hi [aat_pkg::AXES][aat_pkg::AXES];
    logic                         n_ok;

    always_comb begin
        n_ok = 1'b1;
        for (int j = 0; j < aat_pkg::AXES; j++) begin
            lo_c[j] = i_box.mn[j][COORD_BITS-1:0];
            hi_c[j] = i_box.mx[j][COORD_BITS-1:0];
            if (lo_c[j] > hi_c[j]) begin
                n_ok = 1'b0;
            end
        end
        for (int i = 0; i < aat_pkg::AXES; i++) begin
            for (int j = 0; j < aat_pkg::AXES; j++) begin
                m_c[i][j] = i_mat.m[i][j][COORD_BITS-1:0];
                pa[i][j]  = PROD_W'(m_c[i][j]) * PROD_W'(lo_c[j]);
                pb[i][j]  = PROD_W'(m_c[i][j]) * PROD_W'(hi_c[j]);
                // dropping the low bits of a two's complement value floors it
                sa[i][j]  = pa[i][j][PROD_W-1:FRAC_BITS];
                sb[i][j]  = pb[i][j][PROD_W-1:FRAC_BITS];
                if (sa[i][j] < sb[i][j]) begin
                    n_lo[i][j] = sa[i][j];
                    n_hi[i][j] = sb[i][j];
                end else begin
                    n_lo[i][j] = sb[i][j];
                    n_hi[i][j] = sa[i][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lo_term <= n_lo;
            o_hi_term <= n_hi;
            o_box_ok  <= n_ok;
        end
    end

endmodule

FILE: hdl/aat_sum.sv
// ----------------------------------------------------------------------------
// aat_sum
// Sum stage: translation plus ordered terms, saturation, invalid-box clear.
// ----------------------------------------------------------------------------
module aat_sum #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int TERM_W     = 2*COORD_BITS - FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [TERM_W-1:0] i_lo_term [aat_pkg::AXES][aat_pkg::AXES],
    input  logic signed [TERM_W-1:0] i_hi_term [aat_pkg::AXES][aat_pkg::AXES],
    input  logic                     i_box_ok,
    input  aat_pkg::t_matrix         i_mat,
    output aat_pkg::t_box            o_box,
    output logic                     o_box_ok
);

    localparam int SUM_W = TERM_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [COORD_BITS-1:0] t_c     [aat_pkg::AXES];
    logic signed [SUM_W-1:0]      acc_lo  [aat_pkg::AXES];
    logic signed [SUM_W-1:0]      acc_hi  [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] sat_lo  [aat_pkg::AXES];
    logic signed [COORD_BITS-1:0] sat_hi  [aat_pkg::AXES];
    aat_pkg::t_box                n_box;

    always_comb begin
        for (int i = 0; i < aat_pkg::AXES; i++) begin
            t_c[i]    = i_mat.t[i][COORD_BITS-1:0];
            acc_lo[i] = SUM_W'(t_c[i]) + SUM_W'(i_lo_term[i][0])
                      + SUM_W'(i_lo_term[i][1]) + SUM_W'(i_lo_term[i][2]);
            acc_hi[i] = SUM_W'(t_c[i]) + SUM_W'(i_hi_term[i][0])
                      + SUM_W'(i_hi_term[i][1]) + SUM_W'(i_hi_term[i][2]);

            if (acc_lo[i] > SAT_HI)      sat_lo[i] = SAT_HI[COORD_BITS-1:0];
            else if (acc_lo[i] < SAT_LO) sat_lo[i] = SAT_LO[COORD_BITS-1:0];
            else                         sat_lo[i] = acc_lo[i][COORD_BITS-1:0];

            if (acc_hi[i] > SAT_HI)      sat_hi[i] = SAT_HI[COORD_BITS-1:0];
            else if (acc_hi[i] < SAT_LO) sat_hi[i] = SAT_LO[COORD_BITS-1:0];
            else                         sat_hi[i] = acc_hi[i][COORD_BITS-1:0];

            if (i_box_ok) begin
                n_box.mn[i] = aat_pkg::SLOT_W'(sat_lo[i]);
                n_box.mx[i] = aat_pkg::SLOT_W'(sat_hi[i]);
            end else begin
                n_box.mn[i] = '0;
                n_box.mx[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_box    <= n_box;
            o_box_ok <= i_box_ok;
        end
    end

endmodule

FILE: hdl/aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Bounding box of an axis-aligned box after a 3x4 affine matrix (Arvo).
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one box per request: tdata holds the min corner
//   (x, y, z) then the max corner, signed fixed point in 32-bit slots.
//   Master stream returns the transformed box in the same layout, with
//   tuser[0] = 1 for a valid box; an inverted box returns all zero bounds
//   and tuser[0] = 0.
//   The matrix is written through the config port (index 0..5, two entries
//   per 64-bit register) while no request is in flight.
// Timing:
//   Three register stages: input, products, result. A taken request moves
//   through them in that order; one box is accepted every cycle unless
//   the master side stalls. The products stage (eighteen multipliers, one
//   per entry and corner) sets the clock period.
// Reset loads the identity matrix and empties the pipeline.
// A stall on the master side holds the result; each stage keeps taking
// data until it and every stage after it are full, then tready falls.
// ----------------------------------------------------------------------------
module aabb_affine_transform #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write port
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_wdata,
    // request stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each)
    input  logic [191:0]  i_s_axis_tdata,
    // result stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [191:0]  o_m_axis_tdata,
    // box_valid
    output logic [0:0]    o_m_axis_tuser
);

    localparam int TERM_W = 2*COORD_BITS - FRAC_BITS;

    aat_pkg::t_matrix mat;
    aat_pkg::t_box    r_in_box;
    aat_pkg::t_box    out_box;
    logic             r_in_valid, r_prod_valid, r_out_valid;
    logic             in_ready, prod_ready, out_ready;
    logic             prod_ok, out_ok;

    logic signed [TERM_W-1:0] lo_term [aat_pkg::AXES][aat_pkg::AXES];
    logic signed [TERM_W-1:0] hi_term [aat_pkg::AXES][aat_pkg::AXES];

    assign out_ready  = !r_out_valid  || i_m_axis_tready;
    assign prod_ready = !r_prod_valid || out_ready;
    assign in_ready   = !r_in_valid   || prod_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_ready)   r_in_valid   <= i_s_axis_tvalid;
            if (prod_ready) r_prod_valid <= r_in_valid;
            if (out_ready)  r_out_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in_box <= aat_pkg::t_box'(i_s_axis_tdata);
        end
    end

    aat_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mat       (mat)
    );

    aat_prod #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TERM_W     (TERM_W)
    ) u_prod (
        .i_clk     (i_clk),
        .i_en      (prod_ready),
        .i_box     (r_in_box),
        .i_mat     (mat),
        .o_lo_term (lo_term),
        .o_hi_term (hi_term),
        .o_box_ok  (prod_ok)
    );

    aat_sum #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TERM_W     (TERM_W)
    ) u_sum (
        .i_clk     (i_clk),
        .i_en      (out_ready),
        .i_lo_term (lo_term),
        .i_hi_term (hi_term),
        .i_box_ok  (prod_ok),
        .i_mat     (mat),
        .o_box     (out_box),
        .o_box_ok  (out_ok)
    );

    assign o_s_axis_tready   = in_ready;
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = out_box;
    assign o_m_axis_tuser[0] = out_ok;

endmodule

FILE: test/tb_aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// tb_aabb_affine_transform
// Self-checking bench for the affine bounding-box transform. Boxes go in on
// the request stream. Every accepted box is run through a fixed-point
// predictor that holds its own copy of the matrix. Results are compared field
// by field, in order. The matrix is changed between bursts while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module tb_aabb_affine_transform;

    localparam int     FRAC_BITS       = 16;
    localparam longint COORD_MAX       = 64'sd2147483647;
    localparam longint COORD_MIN       = -64'sd2147483648;
    localparam int     SETTLE_CYCLES   = 4;     // pipeline is three registers deep
    localparam int     CYCLE_LIMIT     = 200000;
    localparam int     ITEMS_PER_PHASE = 100;
    localparam int     PHASES          = 5;
    localparam int     HOLD_CYCLES     = 60;
    localparam int     STYLE_SMALL     = 0;
    localparam int     STYLE_FULL      = 1;
    localparam int     STYLE_MIXED     = 2;
    // no register sits at this index, so a write to it must change nothing
    localparam logic [aat_pkg::REG_IDX_W-1:0] REG_IDX_UNUSED = 3'd6;

    typedef struct packed {
        logic          valid;
        aat_pkg::t_box bnd;
    } t_bound_result;

    // ------------------------------------------------------------------------
    // Predictor and ordered store of expected bounding boxes
    // ------------------------------------------------------------------------
    class box_scoreboard;
        logic [aat_pkg::REG_W-1:0] regs [6];
        t_bound_result             expected_boxes [$];
        int                        mismatches;
        int                        boxes_taken;
        int                        results_checked;
        int                        inverted_boxes;
        int                        saturated_bounds;

        function void load_reset();
            regs[aat_pkg::REG_ROW0_C01] = aat_pkg::RST_ROW0_C01;
            regs[aat_pkg::REG_ROW0_C23] = aat_pkg::RST_ROW0_C23;
            regs[aat_pkg::REG_ROW1_C01] = aat_pkg::RST_ROW1_C01;
            regs[aat_pkg::REG_ROW1_C23] = aat_pkg::RST_ROW1_C23;
            regs[aat_pkg::REG_ROW2_C01] = aat_pkg::RST_ROW2_C01;
            regs[aat_pkg::REG_ROW2_C23] = aat_pkg::RST_ROW2_C23;
        endfunction

        function void write_reg(logic [aat_pkg::REG_IDX_W-1:0] idx,
                                logic [aat_pkg::REG_W-1:0] val);
            if (idx <= aat_pkg::REG_ROW2_C23) begin
                regs[idx] = val;
            end
        endfunction

        function logic [aat_pkg::SLOT_W-1:0] clamp(longint v);
            if (v > COORD_MAX) begin
                saturated_bounds++;
                return COORD_MAX[aat_pkg::SLOT_W-1:0];
            end
            if (v < COORD_MIN) begin
                saturated_bounds++;
                return COORD_MIN[aat_pkg::SLOT_W-1:0];
            end
            return v[aat_pkg::SLOT_W-1:0];
        endfunction

        function t_bound_result transform(aat_pkg::t_box b);
            t_bound_result             r;
            longint                    bmin [aat_pkg::AXES];
            longint                    bmax [aat_pkg::AXES];
            longint                    m [aat_pkg::AXES];
            longint                    acc_lo;
            longint                    acc_hi;
            longint                    p;
            longint                    q;
            logic [aat_pkg::REG_W-1:0] c01;
            logic [aat_pkg::REG_W-1:0] c23;
            r.valid = 1'b1;
            r.bnd   = '0;
            for (int a = 0; a < aat_pkg::AXES; a++) begin
                bmin[a] = $signed(b.mn[a]);
                bmax[a] = $signed(b.mx[a]);
                if (bmin[a] > bmax[a]) begin
                    r.valid = 1'b0;
                end
            end
            if (!r.valid) begin
                inverted_boxes++;
                return r;
            end
            for (int row = 0; row < aat_pkg::AXES; row++) begin
                c01    = regs[2*row];
                c23    = regs[2*row+1];
                m[0]   = $signed(c01[31:0]);
                m[1]   = $signed(c01[63:32]);
                m[2]   = $signed(c23[31:0]);
                acc_lo = $signed(c23[63:32]);
                acc_hi = acc_lo;
                for (int col = 0; col < aat_pkg::AXES; col++) begin
                    // exact product, then floor to the fixed-point grid
                    p = (m[col] * bmin[col]) >>> FRAC_BITS;
                    q = (m[col] * bmax[col]) >>> FRAC_BITS;
                    if (p < q) begin
                        acc_lo += p;
                        acc_hi += q;
                    end else begin
                        acc_lo += q;
                        acc_hi += p;
                    end
                end
                r.bnd.mn[row] = clamp(acc_lo);
                r.bnd.mx[row] = clamp(acc_hi);
            end
            return r;
        endfunction

        function void note_request(aat_pkg::t_box b);
            boxes_taken++;
            expected_boxes.push_back(transform(b));
        endfunction

        function void flag_mismatch(string what, logic [aat_pkg::SLOT_W-1:0] want,
                                    logic [aat_pkg::SLOT_W-1:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH result %0d %s: expected %h, got %h",
                         results_checked, what, want, got);
            end
        endfunction

        function void check_result(aat_pkg::t_box got, logic got_valid);
            t_bound_result want;
            if (expected_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH result with no request pending: %h", got);
                end
                return;
            end
            want = expected_boxes.pop_front();
            results_checked++;
            if (got_valid !== want.valid) begin
                flag_mismatch("box_valid", 32'(want.valid), 32'(got_valid));
            end
            for (int a = 0; a < aat_pkg::AXES; a++) begin
                if (got.mn[a] !== want.bnd.mn[a]) begin
                    flag_mismatch($sformatf("min[%0d]", a), want.bnd.mn[a], got.mn[a]);
                end
                if (got.mx[a] !== want.bnd.mx[a]) begin
                    flag_mismatch($sformatf("max[%0d]", a), want.bnd.mx[a], got.mx[a]);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------------
    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_we        = 1'b0;
    logic [aat_pkg::REG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [aat_pkg::REG_W-1:0]     i_cfg_wdata     = '0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    // min_x, min_y, min_z, max_x, max_y, max_z
    logic [191:0]                  i_s_axis_tdata  = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    logic [191:0]                  o_m_axis_tdata;
    // box_valid
    logic [0:0]                    o_m_axis_tuser;

    box_scoreboard sb;
    bit            tx_idle       = 1'b1;
    bit            rx_idle       = 1'b1;
    int            rx_hold_cycles = 0;
    int            holds_done    = 0;
    int            cycles        = 0;

    aabb_affine_transform dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("aabb_affine_transform verification failed");
            $finish;
        end
    end

    // Both handshakes sampled with their pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_request(i_s_axis_tdata);
            end
        end
    end

    // Result sink: random stalls, plus one long hold-off when asked for
    initial begin : result_sink
        int stall;
        forever begin
            if (rx_hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
                holds_done++;
            end
            stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_box(input aat_pkg::t_box b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_boxes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [aat_pkg::REG_IDX_W-1:0] idx,
                             input logic [aat_pkg::REG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    function automatic aat_pkg::t_box box_of(logic [31:0] x0, logic [31:0] y0,
                                             logic [31:0] z0, logic [31:0] x1,
                                             logic [31:0] y1, logic [31:0] z1);
        aat_pkg::t_box b;
        b.mn[0] = x0;
        b.mn[1] = y0;
        b.mn[2] = z0;
        b.mx[0] = x1;
        b.mx[1] = y1;
        b.mx[2] = z1;
        return b;
    endfunction

    function automatic logic [31:0] random_entry(int style);
        int pick;
        pick = (style == STYLE_MIXED) ? $urandom_range(STYLE_SMALL, STYLE_FULL) : style;
        if ($urandom_range(0, 7) == 0) begin
            return '0;
        end
        if (pick == STYLE_FULL) begin
            return $urandom;
        end
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;   // within +/-4.0
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int            phase;
        int            n;
        int            ax;
        int            style;
        int            settings;
        bit            wide;
        aat_pkg::t_box b;
        logic [31:0]   p;
        logic [31:0]   q;
        logic [31:0]   tmp;

        sb = new;
        sb.load_reset();
        settings = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity matrix out of reset
        send_box(box_of(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                        32'h0004_0000, 32'h0005_0000, 32'h0006_0000));
        send_box(box_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_box(box_of(32'hffff_8000, 32'hffff_8000, 32'hffff_8000,
                        32'hffff_8000, 32'hffff_8000, 32'hffff_8000));
        // inverted on each axis in turn
        send_box(box_of(32'h0002_0000, 32'h0000_0000, 32'h0000_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_box(box_of(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000,
                        32'h0001_0000, 32'h8000_0000, 32'h0001_0000));
        send_box(box_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
                        32'h0001_0000, 32'h0001_0000, 32'h0000_0000));
        send_box(box_of(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_box(box_of('0, '0, '0, '0, '0, '0));
        drain();

        // Extreme matrix: saturation both ways and floor rounding of tiny products
        cfg_write(aat_pkg::REG_ROW0_C01, {32'h8000_0000, 32'h7fff_ffff});
        cfg_write(aat_pkg::REG_ROW0_C23, {32'h7fff_ffff, 32'h0000_8000});
        cfg_write(aat_pkg::REG_ROW1_C01, {32'h8000_0000, 32'h8000_0000});
        cfg_write(aat_pkg::REG_ROW1_C23, {32'h8000_0000, 32'hffff_ffff});
        cfg_write(aat_pkg::REG_ROW2_C01, {32'hffff_8000, 32'h0000_0001});
        cfg_write(aat_pkg::REG_ROW2_C23, {32'h0000_0000, 32'h7fff_ffff});
        cfg_write(REG_IDX_UNUSED, '1);
        settings++;
        send_box(box_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_box(box_of(32'hffff_ffff, 32'hffff_fffd, 32'hffff_ffff,
                        32'h0000_0001, 32'h0000_0003, 32'h0000_0005));
        send_box(box_of('0, '0, '0, '0, '0, '0));
        send_box(box_of(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_box(box_of(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        send_box(box_of(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_box(box_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        drain();

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES - 1) begin
                // back to identity by writing the reset values
                cfg_write(aat_pkg::REG_ROW0_C01, aat_pkg::RST_ROW0_C01);
                cfg_write(aat_pkg::REG_ROW0_C23, aat_pkg::RST_ROW0_C23);
                cfg_write(aat_pkg::REG_ROW1_C01, aat_pkg::RST_ROW1_C01);
                cfg_write(aat_pkg::REG_ROW1_C23, aat_pkg::RST_ROW1_C23);
                cfg_write(aat_pkg::REG_ROW2_C01, aat_pkg::RST_ROW2_C01);
                cfg_write(aat_pkg::REG_ROW2_C23, aat_pkg::RST_ROW2_C23);
            end else begin
                style = (phase == 1) ? STYLE_FULL : (phase == 2) ? STYLE_MIXED : STYLE_SMALL;
                for (int r = aat_pkg::REG_ROW0_C01; r <= aat_pkg::REG_ROW2_C23; r++) begin
                    cfg_write(aat_pkg::REG_IDX_W'(r),
                              {random_entry(style), random_entry(style)});
                end
            end
            settings++;
            tx_idle = (phase != 1 && phase != 2);
            rx_idle = (phase != 1);
            if (phase == 2) begin
                // sender runs flat out while the sink holds off
                rx_hold_cycles = HOLD_CYCLES;
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) begin
                    drain();
                end
                wide = ($urandom_range(0, 3) == 0);
                for (ax = 0; ax < aat_pkg::AXES; ax++) begin
                    p = wide ? $urandom : ($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
                    q = wide ? $urandom : ($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
                    if ($signed(p) > $signed(q)) begin
                        tmp = p;
                        p   = q;
                        q   = tmp;
                    end
                    b.mn[ax] = p;
                    b.mx[ax] = q;
                end
                ax = $urandom_range(0, aat_pkg::AXES - 1);
                if ($urandom_range(0, 99) < 12 && b.mn[ax] != b.mx[ax]) begin
                    tmp      = b.mn[ax];
                    b.mn[ax] = b.mx[ax];
                    b.mx[ax] = tmp;
                end else if ($urandom_range(0, 19) == 0) begin
                    b.mx[ax] = b.mn[ax];
                end
                send_box(b);
            end
            drain();
        end

        $display("%0d boxes through %0d matrix settings: %0d inverted, %0d saturated bounds",
                 sb.boxes_taken, settings, sb.inverted_boxes, sb.saturated_bounds);
        $display("%0d results checked, %0d long sink hold-offs, %0d mismatches",
                 sb.results_checked, holds_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_boxes.size() == 0) begin
            $display("aabb_affine_transform verification clean");
        end else begin
            $display("aabb_affine_transform verification failed");
        end
        $finish;
    end

endmodule
